FILE: hw/rtl/crcrx_pkg.sv
// Shared types, codes and the CRC-8 step for the COBS receive packet checker.
// Used by the front classifier, the item queue, the decode engine and the top level.
package crcrx_pkg;

   // CRC-8 generator polynomial x^8 + x^2 + x + 1, no reflection, initial value zero.
   localparam logic [7:0] CRC_POLY      = 8'h07;
   // A group code of 0xFF carries 254 data bytes and no implied zero.
   localparam logic [7:0] FULL_GROUP    = 8'hFF;
   // Packet id, command id and CRC byte: the shortest frame that is well formed.
   localparam int         MIN_FRAME     = 3;

   localparam int         QUEUE_DEPTH   = 4;
   localparam int         QUEUE_PTR_W   = 2;

   localparam int         FREE_W        = 13;
   localparam int         LEN_W         = 9;

   // Kinds of result transaction.
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_VERDICT  = 2'd1;
   localparam logic [1:0] KIND_ACK      = 2'd2;

   // Frame verdicts.
   localparam logic [2:0] STAT_ACCEPTED  = 3'd0;
   localparam logic [2:0] STAT_CRC_ERROR = 3'd1;
   localparam logic [2:0] STAT_LOST      = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_MALFORMED = 3'd4;

   // Acknowledge report codes.
   localparam logic [1:0] ACK_OK         = 2'd0;
   localparam logic [1:0] RPT_CRC_ERR    = 2'd1;
   localparam logic [1:0] RPT_SEQ_GAP    = 2'd2;
   localparam logic [1:0] RPT_NO_ROOM    = 2'd3;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_DELIM,
      OP_ACK_TAKE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         rx_byte;
      logic [FREE_W-1:0]  free_bytes;
   } queue_item_type;

   // Result payload, packed from the lowest bit up in the order of the bus.
   typedef struct packed {
      logic [1:0]         ack_status;
      logic [7:0]         ack_packet;
      logic               ack_valid;
      logic [LEN_W-1:0]   frame_length;
      logic [7:0]         command_id;
      logic [7:0]         packet_id;
      logic [2:0]         frame_status;
      logic [7:0]         data_byte;
   } rsp_item_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] r;
      r = crc ^ d;
      for (int i = 0; i < 8; i++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/cobs_crc8_rx_packet_checker.sv
// Top level of the COBS receive packet checker with CRC-8 and sequence acknowledgement.
// Instantiates crcrx_front, crcrx_queue and crcrx_engine; depends on crcrx_pkg.
//
// While req_tready is high, the block takes one request transaction per clock cycle:
// either a received link byte (tuser low) or a request to take the pending acknowledge
// report (tuser high). Link bytes are COBS-decoded on the fly; a zero byte closes
// the frame and produces a verdict transaction carrying the packet id, command id,
// decoded length and a status of accepted, CRC error, lost, full or malformed.
// Decoded payload bytes leave one byte late, so the trailing CRC byte is never
// passed on. A classifier writes every request into a four-entry queue, and the
// decode engine drains that queue at one transaction per cycle into a registered
// result stage, so a steady rate of one transaction per cycle is sustained while
// the result side keeps up. The result of a request becomes valid once it has passed
// through its queue entry and then the registered result stage. When the result
// side stalls, up to four further requests are absorbed before req_tready falls.
// Many link bytes produce no result at all (group codes, header bytes), which lets
// the queue drain quickly after a stall.
// The reserved command register is written through csr_wr_en and csr_wr_data and
// should only be changed while the block is idle. There is no clearing pass after
// reset.
module cobs_crc8_rx_packet_checker #(
   parameter int FRAME_MAX_BYTES = 256,
   parameter int STORE_ALIGN     = 4
) (
   input  logic        clock,
   input  logic        reset,

   // Reserved command id: frames carrying it skip the sequence and report logic.
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,     // action (0 link byte, 1 take acknowledge report)
   input  logic [23:0] req_tdata,     // rx_byte[7:0], rx_free_bytes[20:8], zero[23:21]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,     // kind (0 payload, 1 verdict, 2 acknowledge report)
   // data_byte[7:0], frame_status[10:8], packet_id[18:11], command_id[26:19],
   // frame_length[35:27], ack_valid[36], ack_packet[44:37], ack_status[46:45], zero[47]
   output logic [47:0] rsp_tdata
);
   import crcrx_pkg::*;

   logic           push_valid;
   queue_item_type push_item;
   logic           queue_full;
   logic           queue_not_empty;
   queue_item_type head_item;
   logic           item_pop;
   rsp_item_type   rsp_item;

   crcrx_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   crcrx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (item_pop),
      .not_empty  (queue_not_empty),
      .head_item  (head_item)
   );

   crcrx_engine #(
      .FRAME_MAX_BYTES (FRAME_MAX_BYTES),
      .STORE_ALIGN     (STORE_ALIGN)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (queue_not_empty),
      .item        (head_item),
      .item_pop    (item_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_kind    (rsp_tuser),
      .rsp_item    (rsp_item)
   );

   // The result struct is already laid out in bus order; the top bit pads to bytes.
   assign rsp_tdata = {1'b0, rsp_item};

endmodule

FILE: hw/rtl/crcrx_front.sv
// Front classifier: takes request transactions and sorts them into link bytes,
// frame delimiters and report requests for the item queue. Depends on crcrx_pkg.
module crcrx_front (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_tuser,
   input  logic [23:0]              req_tdata,
   input  logic                     queue_full,
   output logic                     push_valid,
   output crcrx_pkg::queue_item_type push_item
);
   import crcrx_pkg::*;

   logic [7:0] rx_byte;

   assign rx_byte    = req_tdata[7:0];
   assign req_tready = !queue_full;
   assign push_valid = req_tvalid && !queue_full;

   always_comb begin
      push_item.rx_byte    = rx_byte;
      push_item.free_bytes = req_tdata[8 +: FREE_W];
      if (req_tuser) begin
         push_item.op = OP_ACK_TAKE;
      end else if (rx_byte == 8'h00) begin
         push_item.op = OP_DELIM;
      end else begin
         push_item.op = OP_BYTE;
      end
   end

endmodule

FILE: hw/rtl/crcrx_queue.sv
// Short first-in first-out queue of classified items between the front and the
// decode engine. Depends on crcrx_pkg for the item type and depth.
module crcrx_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  crcrx_pkg::queue_item_type push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     not_empty,
   output crcrx_pkg::queue_item_type head_item
);
   import crcrx_pkg::*;

   queue_item_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     do_pop;

   assign full      = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/crcrx_engine.sv
// Decode engine: COBS decoding, CRC-8 check, sequence and acknowledge tracking,
// and the registered result stage. Depends on crcrx_pkg.
module crcrx_engine #(
   parameter int FRAME_MAX_BYTES = 256,
   parameter int STORE_ALIGN     = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [7:0]                csr_wr_data,
   input  logic                      item_valid,
   input  crcrx_pkg::queue_item_type item,
   output logic                      item_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output crcrx_pkg::rsp_item_type   rsp_item
);
   import crcrx_pkg::*;

   localparam int CNT_W = $clog2(FRAME_MAX_BYTES + 1);
   localparam int CMP_W = ((CNT_W > FREE_W) ? CNT_W : FREE_W) + 4;

   logic              bypass_wr;
   logic [7:0]        bypass_cmd_ff;

   logic              first_ff, first_in;
   logic [7:0]        last_id_ff, last_id_in;
   logic              ack_pend_ff, ack_pend_in;
   logic [7:0]        ack_pkt_ff, ack_pkt_in;
   logic [1:0]        ack_stat_ff, ack_stat_in;
   logic [7:0]        left_ff, left_in;
   logic              below_ff, below_in;
   logic              zero_pend_ff, zero_pend_in;
   logic [7:0]        crc_ff, crc_in;
   logic [7:0]        held_ff, held_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [7:0]        pid_ff, pid_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic              bad_ff, bad_in;

   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_kind_ff, out_kind_in;
   rsp_item_type      out_item_ff, out_item_in;

   logic              res_valid;
   logic              take_en;
   logic [7:0]        take_d;
   logic [7:0]        crc_next;
   logic [7:0]        last_eff;
   logic [CMP_W-1:0]  need_bytes;
   logic              fits;
   logic [CNT_W+LEN_W-1:0] cnt_ext;

   assign item_pop  = item_valid && (!out_valid_ff || rsp_ready);
   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_item  = out_item_ff;

   assign last_eff   = first_ff ? pid_ff - 8'd1 : last_id_ff;
   assign need_bytes = CMP_W'(cnt_ff) + CMP_W'(STORE_ALIGN);
   assign fits       = CMP_W'(item.free_bytes) > need_bytes;
   assign cnt_ext    = (CNT_W + LEN_W)'(cnt_ff);

   always_comb begin
      first_in     = first_ff;
      last_id_in   = last_id_ff;
      ack_pend_in  = ack_pend_ff;
      ack_pkt_in   = ack_pkt_ff;
      ack_stat_in  = ack_stat_ff;
      left_in      = left_ff;
      below_in     = below_ff;
      zero_pend_in = zero_pend_ff;
      crc_in       = crc_ff;
      held_in      = held_ff;
      cnt_in       = cnt_ff;
      pid_in       = pid_ff;
      cmd_in       = cmd_ff;
      bad_in       = bad_ff;
      res_valid    = 1'b0;
      out_kind_in  = KIND_PAYLOAD;
      out_item_in  = '0;
      take_en      = 1'b0;
      take_d       = item.rx_byte;
      crc_next     = 8'h00;

      if (item_pop) begin
         case (item.op)
            OP_ACK_TAKE: begin
               res_valid              = 1'b1;
               out_kind_in            = KIND_ACK;
               out_item_in.ack_valid  = ack_pend_ff;
               out_item_in.ack_packet = ack_pkt_ff;
               out_item_in.ack_status = ack_stat_ff;
               ack_pend_in            = 1'b0;
               ack_pkt_in             = 8'h00;
               ack_stat_in            = ACK_OK;
            end
            OP_DELIM: begin
               res_valid                = 1'b1;
               out_kind_in              = KIND_VERDICT;
               out_item_in.packet_id    = pid_ff;
               out_item_in.command_id   = cmd_ff;
               out_item_in.frame_length = cnt_ext[LEN_W-1:0];
               if (bad_ff || left_ff != 8'h00 || cnt_ff < CNT_W'(MIN_FRAME)) begin
                  out_item_in.frame_status = STAT_MALFORMED;
               end else if (crc_ff != held_ff) begin
                  out_item_in.frame_status = STAT_CRC_ERROR;
               end else begin
                  first_in   = 1'b0;
                  last_id_in = last_eff;
                  if (cmd_ff == bypass_cmd_ff) begin
                     out_item_in.frame_status = STAT_ACCEPTED;
                  end else if (pid_ff != last_eff + 8'd1) begin
                     out_item_in.frame_status = STAT_LOST;
                     if (!ack_pend_ff || ack_stat_ff == ACK_OK) begin
                        ack_pkt_in  = last_eff + 8'd1;
                        ack_stat_in = RPT_SEQ_GAP;
                        ack_pend_in = 1'b1;
                     end
                  end else if (!fits) begin
                     out_item_in.frame_status = STAT_FULL;
                     if (!ack_pend_ff || ack_stat_ff == ACK_OK) begin
                        ack_pkt_in  = last_eff + 8'd1;
                        ack_stat_in = RPT_NO_ROOM;
                        ack_pend_in = 1'b1;
                     end
                  end else begin
                     out_item_in.frame_status = STAT_ACCEPTED;
                     if (!ack_pend_ff || ack_stat_ff == ACK_OK) begin
                        ack_pkt_in  = pid_ff;
                        ack_pend_in = 1'b1;
                     end
                     last_id_in = pid_ff;
                  end
               end
               left_in      = 8'h00;
               below_in     = 1'b0;
               zero_pend_in = 1'b0;
               crc_in       = 8'h00;
               held_in      = 8'h00;
               cnt_in       = '0;
               pid_in       = 8'h00;
               cmd_in       = 8'h00;
               bad_in       = 1'b0;
            end
            OP_BYTE: begin
               if (left_ff == 8'h00) begin
                  // A new group code: release the implied zero of the group before.
                  take_en      = zero_pend_ff;
                  take_d       = 8'h00;
                  zero_pend_in = (item.rx_byte == 8'h01);
                  left_in      = item.rx_byte - 8'd1;
                  below_in     = (item.rx_byte != FULL_GROUP);
               end else begin
                  take_en = 1'b1;
                  left_in = left_ff - 8'd1;
                  if (left_ff == 8'h01 && below_ff) begin
                     zero_pend_in = 1'b1;
                  end
               end

               // Header bytes feed the CRC directly; later bytes pass through the hold
               // register, so the CRC byte itself is never folded in.
               crc_next = crc8_update(crc_ff, (cnt_ff < CNT_W'(2)) ? take_d : held_ff);
               if (take_en && !bad_ff) begin
                  if (cnt_ff >= CNT_W'(FRAME_MAX_BYTES)) begin
                     bad_in = 1'b1;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                     if (cnt_ff == CNT_W'(0)) begin
                        pid_in = take_d;
                        crc_in = crc_next;
                     end else if (cnt_ff == CNT_W'(1)) begin
                        cmd_in = take_d;
                        crc_in = crc_next;
                     end else if (cnt_ff == CNT_W'(2)) begin
                        held_in = take_d;
                     end else begin
                        res_valid             = 1'b1;
                        out_kind_in           = KIND_PAYLOAD;
                        out_item_in.data_byte = held_ff;
                        crc_in                = crc_next;
                        held_in               = take_d;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign bypass_wr = csr_wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_cmd_ff   <= 8'h00;
         first_ff        <= 1'b1;
         last_id_ff      <= 8'h00;
         ack_pend_ff     <= 1'b0;
         ack_pkt_ff      <= 8'h00;
         ack_stat_ff     <= ACK_OK;
         left_ff         <= 8'h00;
         below_ff        <= 1'b0;
         zero_pend_ff    <= 1'b0;
         crc_ff          <= 8'h00;
         held_ff         <= 8'h00;
         cnt_ff          <= '0;
         pid_ff          <= 8'h00;
         cmd_ff          <= 8'h00;
         bad_ff          <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (bypass_wr) begin
            bypass_cmd_ff <= csr_wr_data;
         end
         first_ff     <= first_in;
         last_id_ff   <= last_id_in;
         ack_pend_ff  <= ack_pend_in;
         ack_pkt_ff   <= ack_pkt_in;
         ack_stat_ff  <= ack_stat_in;
         left_ff      <= left_in;
         below_ff     <= below_in;
         zero_pend_ff <= zero_pend_in;
         crc_ff       <= crc_in;
         held_ff      <= held_in;
         cnt_ff       <= cnt_in;
         pid_ff       <= pid_in;
         cmd_ff       <= cmd_in;
         bad_ff       <= bad_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         out_kind_ff <= out_kind_in;
         out_item_ff <= out_item_in;
      end
   end

endmodule

FILE: dv/cobs_crc8_rx_packet_checker_test.sv
// Self-checking testbench for the COBS receive packet checker with CRC-8 and acknowledgement.
// Depends on crcrx_pkg and cobs_crc8_rx_packet_checker; holds its own scoreboard and
// stimulus.
module cobs_crc8_rx_packet_checker_test;
   import crcrx_pkg::*;

   localparam int FRAME_MAX_BYTES = 256;
   localparam int STORE_ALIGN     = 4;

   typedef bit [7:0] byte_q_type[$];

   // One expected result transaction: the kind carried on tuser and the tdata fields.
   typedef struct packed {
      logic [1:0]   kind;
      rsp_item_type body;
   } rsp_expect_type;

   // The scoreboard keeps its own copy of the deframer state. Every accepted request is
   // played through it at once, and the result it causes, if any, waits in a queue until
   // the block delivers the matching transaction.
   class deframe_scoreboard #(int MAX_BYTES = 256, int ALIGN = 4);
      bit [7:0]       bypass_cmd;
      bit             first_frame;
      bit [7:0]       last_id;
      bit             ack_pending;
      bit [7:0]       ack_packet;
      bit [1:0]       ack_code;
      bit [7:0]       group_left;
      bit             group_short;
      bit             zero_due;
      bit [7:0]       crc;
      bit [7:0]       held;
      bit [8:0]       count;
      bit [7:0]       frame_pid;
      bit [7:0]       frame_cmd;
      bit             frame_bad;
      rsp_expect_type expected_q[$];
      int             errors;

      function new();
         bypass_cmd   = 8'h00;
         first_frame  = 1'b1;
         last_id      = 8'h00;
         ack_pending  = 1'b0;
         ack_packet   = 8'h00;
         ack_code     = ACK_OK;
         errors       = 0;
         clear_frame();
      endfunction

      function bit [7:0] crc8_step(bit [7:0] c, bit [7:0] d);
         bit [7:0] r;
         bit       fb;
         r = c;
         // Bit-serial form, data MSB first.
         for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ d[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
         end
         return r;
      endfunction

      function void set_reserved(bit [7:0] v);
         bypass_cmd = v;
      endfunction

      function bit [7:0] next_packet_id();
         return last_id + 8'd1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void clear_frame();
         group_left  = 8'h00;
         group_short = 1'b0;
         zero_due    = 1'b0;
         crc         = 8'h00;
         held        = 8'h00;
         count       = '0;
         frame_pid   = 8'h00;
         frame_cmd   = 8'h00;
         frame_bad   = 1'b0;
      endfunction

      // A pending NACK is sticky: only an empty report or a plain ACK is replaced.
      function void raise_nack(bit [1:0] code);
         if (!ack_pending || ack_code == ACK_OK) begin
            ack_packet  = last_id + 8'd1;
            ack_code    = code;
            ack_pending = 1'b1;
         end
      endfunction

      // Takes one decoded byte. Returns 1 when the previously held payload byte leaves.
      function bit decode_byte(bit [7:0] d, output bit [7:0] pay);
         bit [8:0] idx;
         idx = count;
         pay = 8'h00;
         if (frame_bad)
            return 1'b0;
         if (idx >= MAX_BYTES) begin
            frame_bad = 1'b1;
            return 1'b0;
         end
         count = idx + 9'd1;
         if (idx == 9'd0) begin
            frame_pid = d;
            crc       = crc8_step(crc, d);
            return 1'b0;
         end
         if (idx == 9'd1) begin
            frame_cmd = d;
            crc       = crc8_step(crc, d);
            return 1'b0;
         end
         if (idx == 9'd2) begin
            held = d;
            return 1'b0;
         end
         pay  = held;
         crc  = crc8_step(crc, held);
         held = d;
         return 1'b1;
      endfunction

      function bit [2:0] judge_frame(bit [12:0] free);
         if (frame_bad || group_left != 8'h00 || count < MIN_FRAME)
            return STAT_MALFORMED;
         if (crc != held)
            return STAT_CRC_ERROR;
         if (first_frame) begin
            last_id     = frame_pid - 8'd1;
            first_frame = 1'b0;
         end
         if (frame_cmd == bypass_cmd)
            return STAT_ACCEPTED;
         if (frame_pid != last_id + 8'd1) begin
            raise_nack(RPT_SEQ_GAP);
            return STAT_LOST;
         end
         if (int'(free) <= int'(count) + ALIGN) begin
            raise_nack(RPT_NO_ROOM);
            return STAT_FULL;
         end
         if (!ack_pending || ack_code == ACK_OK) begin
            ack_packet  = frame_pid;
            ack_pending = 1'b1;
         end
         last_id = frame_pid;
         return STAT_ACCEPTED;
      endfunction

      function void note_request(bit action, bit [7:0] b, bit [12:0] free);
         rsp_expect_type e;
         bit [7:0]       pay;
         bit             emit;
         e = '0;
         if (action) begin
            e.kind            = KIND_ACK;
            e.body.ack_valid  = ack_pending;
            e.body.ack_packet = ack_packet;
            e.body.ack_status = ack_code;
            ack_pending = 1'b0;
            ack_packet  = 8'h00;
            ack_code    = ACK_OK;
            expected_q.push_back(e);
            return;
         end
         if (b == 8'h00) begin
            e.kind              = KIND_VERDICT;
            e.body.frame_length = count;
            e.body.frame_status = judge_frame(free);
            e.body.packet_id    = frame_pid;
            e.body.command_id   = frame_cmd;
            clear_frame();
            expected_q.push_back(e);
            return;
         end
         emit = 1'b0;
         if (group_left == 8'h00) begin
            // A group code: the implied zero of the previous short group is only
            // released now, so the one at the end of a frame never appears.
            if (zero_due) begin
               zero_due = 1'b0;
               emit     = decode_byte(8'h00, pay);
            end
            group_left  = b - 8'd1;
            group_short = (b < FULL_GROUP);
            if (group_left == 8'h00 && group_short)
               zero_due = 1'b1;
         end else begin
            group_left = group_left - 8'd1;
            if (group_left == 8'h00 && group_short)
               zero_due = 1'b1;
            emit = decode_byte(b, pay);
         end
         if (emit) begin
            e.kind           = KIND_PAYLOAD;
            e.body.data_byte = pay;
            expected_q.push_back(e);
         end
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(logic [1:0] kind, logic [47:0] data);
         rsp_expect_type e;
         rsp_item_type   got;
         got = data[46:0];
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                     $time, kind, data);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("kind", 16'(e.kind), 16'(kind));
         compare_field("data_byte", 16'(e.body.data_byte), 16'(got.data_byte));
         compare_field("frame_status", 16'(e.body.frame_status), 16'(got.frame_status));
         compare_field("packet_id", 16'(e.body.packet_id), 16'(got.packet_id));
         compare_field("command_id", 16'(e.body.command_id), 16'(got.command_id));
         compare_field("frame_length", 16'(e.body.frame_length), 16'(got.frame_length));
         compare_field("ack_valid", 16'(e.body.ack_valid), 16'(got.ack_valid));
         compare_field("ack_packet", 16'(e.body.ack_packet), 16'(got.ack_packet));
         compare_field("ack_status", 16'(e.body.ack_status), 16'(got.ack_status));
         compare_field("spare bit", 16'h0000, 16'(data[47]));
      endfunction
   endclass

   typedef deframe_scoreboard #(FRAME_MAX_BYTES, STORE_ALIGN) deframe_sb_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;
   logic [47:0] rsp_tdata;

   deframe_sb_type sb;
   int             send_idle_pct;
   int             recv_stall_pct;
   int             report_mix_pct;
   int             items_sent;

   cobs_crc8_rx_packet_checker #(
      .FRAME_MAX_BYTES(FRAME_MAX_BYTES),
      .STORE_ALIGN    (STORE_ALIGN)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offers one request transaction and returns at the edge that accepts it. The valid
   // is left high on return, so that a following transaction can go straight out; an
   // idle gap lowers it again. Each path makes one assignment per time step.
   task automatic send_item(input bit action, input bit [7:0] b, input bit [12:0] free);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {3'b000, free, b};
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      sb.note_request(action, b, free);
      items_sent++;
   endtask

   // Free space values spread from 0 to 4096, the two extremes included.
   function automatic bit [12:0] any_free();
      case ($urandom_range(3))
         0: return 13'd0;
         1: return 13'd4096;
         default: return 13'($urandom_range(4096));
      endcase
   endfunction

   // Free space that lets a frame of the given decoded length fit, often just so.
   function automatic bit [12:0] fit_free(int len);
      case ($urandom_range(3))
         0: return 13'(len + STORE_ALIGN + 1);
         1: return 13'd4096;
         default: return 13'($urandom_range(4096, len + STORE_ALIGN + 1));
      endcase
   endfunction

   function automatic byte_q_type random_bytes(int len, int zero_pct);
      byte_q_type q;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < zero_pct)
            q.push_back(8'h00);
         else
            q.push_back(8'($urandom_range(255, 1)));
      end
      return q;
   endfunction

   // Standard COBS encoding. When the data ends exactly on a full group, tail_code
   // selects whether the usual trailing 0x01 code follows it or the frame ends on 0xFF.
   function automatic byte_q_type cobs_encode(byte_q_type dec, bit tail_code);
      byte_q_type enc;
      int         code_at;
      bit [7:0]   code;
      enc.push_back(8'h00);
      code_at = 0;
      code    = 8'h01;
      for (int i = 0; i < dec.size(); i++) begin
         if (dec[i] == 8'h00) begin
            enc[code_at] = code;
            code_at      = enc.size();
            enc.push_back(8'h00);
            code = 8'h01;
         end else begin
            enc.push_back(dec[i]);
            code++;
            if (code == FULL_GROUP) begin
               enc[code_at] = code;
               if (i == dec.size() - 1 && !tail_code) begin
                  code_at = -1;
               end else begin
                  code_at = enc.size();
                  enc.push_back(8'h00);
                  code = 8'h01;
               end
            end
         end
      end
      if (code_at >= 0)
         enc[code_at] = code;
      return enc;
   endfunction

   // Sends a stream of link bytes and closes it with a delimiter. Report requests are
   // scattered in at random, also in the middle of a frame.
   task automatic send_stream(input byte_q_type enc, input bit [12:0] free_end);
      foreach (enc[i]) begin
         if ($urandom_range(99) < report_mix_pct)
            send_item(1'b1, 8'($urandom), any_free());
         send_item(1'b0, enc[i], any_free());
      end
      send_item(1'b0, 8'h00, free_end);
   endtask

   // Builds a frame of header, payload and CRC, encodes it and sends it. A non-zero
   // crc_flip spoils the CRC byte; a cut of zero or more truncates the encoded stream.
   task automatic send_frame(input bit [7:0] pid, input bit [7:0] cmd, input byte_q_type pay,
                             input bit [7:0] crc_flip, input bit [12:0] free_end,
                             input int cut, input bit tail_code);
      byte_q_type dec;
      byte_q_type enc;
      bit [7:0]   c;
      dec.push_back(pid);
      dec.push_back(cmd);
      foreach (pay[i])
         dec.push_back(pay[i]);
      c = 8'h00;
      foreach (dec[i])
         c = sb.crc8_step(c, dec[i]);
      dec.push_back(c ^ crc_flip);
      enc = cobs_encode(dec, tail_code);
      while (cut >= 0 && enc.size() > cut)
         void'(enc.pop_back());
      send_stream(enc, free_end);
   endtask

   // Random traffic. Most frames are well formed and carry the packet id that the block
   // expects next, so the sequence and report logic is exercised deeply; the rest are
   // broken in one way or another. One long frame goes out early in every call: one that
   // ends on a full group under full_group_run, else one of the largest length or more.
   task automatic run_random(input int quota, input bit [7:0] reserved,
                             input bit full_group_run);
      int         stop;
      int         frames;
      int         pick;
      int         len;
      bit [7:0]   pid;
      bit [7:0]   cmd;
      byte_q_type pay;
      stop   = items_sent + quota;
      frames = 0;
      while (items_sent < stop) begin
         pick = $urandom_range(99);
         pid  = sb.next_packet_id();
         cmd  = ($urandom_range(99) < 25) ? reserved : 8'($urandom);
         pay  = random_bytes($urandom_range(12), 25);
         len  = pay.size() + MIN_FRAME;
         if (frames == 3 && !full_group_run) begin
            // Over-long frame, or one that decodes to exactly the largest length.
            pay = random_bytes(($urandom_range(1) != 0) ? FRAME_MAX_BYTES - MIN_FRAME
                                                        : int'($urandom_range(290, 254)),
                               10);
            send_frame(pid, cmd, pay, 8'h00, 13'd4096, -1, 1'($urandom_range(1)));
         end else if (frames == 3) begin
            // Header, payload and CRC fill one group of 254 bytes with no zero after it.
            pay = random_bytes(int'(FULL_GROUP) - 1 - MIN_FRAME, 0);
            send_frame(pid, cmd, pay, 8'h00, 13'd4096, -1, 1'b0);
         end else if (pick < 50) begin
            send_frame(pid, cmd, pay, 8'h00, fit_free(len), -1, 1'($urandom_range(1)));
         end else if (pick < 58) begin
            send_frame(pid, cmd, pay, 8'($urandom_range(255, 1)), fit_free(len), -1, 1'b1);
         end else if (pick < 66) begin
            pid = pid + 8'($urandom_range(255, 1));
            send_frame(pid, cmd, pay, 8'h00, fit_free(len), -1, 1'b1);
         end else if (pick < 74) begin
            cmd = reserved ^ 8'($urandom_range(255, 1));
            send_frame(pid, cmd, pay, 8'h00,
                       13'(($urandom_range(1) != 0) ? len + STORE_ALIGN
                                                    : $urandom_range(len + STORE_ALIGN)),
                       -1, 1'b1);
         end else if (pick < 80) begin
            send_frame(pid, cmd, pay, 8'h00, fit_free(len), int'($urandom_range(len)), 1'b1);
         end else if (pick < 86) begin
            send_stream(cobs_encode(random_bytes($urandom_range(2), 30),
                                    1'($urandom_range(1))),
                        any_free());
         end else if (pick < 92) begin
            send_stream(random_bytes($urandom_range(16, 1), 0), any_free());
         end else begin
            repeat ($urandom_range(3, 1))
               send_item(1'b1, 8'($urandom), any_free());
         end
         frames++;
      end
   endtask

   // Lets the block run dry: every expected result in, then a further wait so that
   // link bytes that cause no result have also left the queue and the decode engine.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reserved(input bit [7:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.set_reserved(v);
      csr_wr_en   <= 1'b0;
   endtask

   // Result side: checks each transaction taken and stalls at random by the current rate.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            sb.check_response(rsp_tuser, rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Main sequence: three phases, each with its own idling pattern and its own reserved
   // command. The first phase opens with a short directed run through the corner cases.
   initial begin
      byte_q_type pay;
      byte_q_type enc;
      bit [7:0]   reserved;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 8'h00;
      req_tvalid  <= 1'b0;
      req_tuser   <= 1'b0;
      req_tdata   <= '0;
      sb             = new();
      items_sent     = 0;
      report_mix_pct = 0;
      send_idle_pct  = 30;
      recv_stall_pct = 47;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 30;
               recv_stall_pct = 47;
               reserved       = 8'h00;
            end
            1: begin
               send_idle_pct  = 47;
               recv_stall_pct = 30;
               reserved       = 8'hFF;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               reserved       = 8'($urandom_range(254, 1));
            end
         endcase
         settle();
         write_reserved(reserved);

         if (phase == 0) begin
            // Report taken with nothing pending, then an empty frame.
            send_item(1'b1, 8'hFF, 13'd4096);
            send_item(1'b0, 8'h00, 13'd0);
            // Only two decoded bytes: too short.
            enc = '{8'h03, 8'h10, 8'h22};
            send_stream(enc, 13'd4096);
            // Delimiter while a group still expects bytes: truncated.
            enc = '{8'h05, 8'h11, 8'h22};
            send_stream(enc, 13'd4096);
            // First good frame sets the sequence; it carries a zero and an 0xFF byte.
            pay = '{8'h00, 8'hFF};
            send_frame(8'hFF, 8'h01, pay, 8'h00, 13'd4096, -1, 1'b1);
            // Sequence gap, which leaves a lost NACK for the report taken next.
            pay = {};
            send_frame(8'h40, 8'h03, pay, 8'h00, 13'd4096, -1, 1'b1);
            send_item(1'b1, 8'h00, 13'd1);
            // Reserved command goes through even without room downstream.
            send_frame(8'h00, reserved, pay, 8'h00, 13'd0, -1, 1'b1);
            report_mix_pct = 4;
         end

         run_random(505, reserved, phase == 1);
      end

      settle();
      if (sb.errors == 0)
         $display("cobs_crc8_rx_packet_checker_test passed");
      else
         $display("cobs_crc8_rx_packet_checker_test failed");
      $finish;
   end

   // Guard against a hung handshake; the normal run needs a small part of this.
   initial begin
      #3000000;
      $display("cobs_crc8_rx_packet_checker_test failed");
      $finish;
   end

endmodule
